>>> src/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// shared widths, reset values and register indexes of the empty square finder
// ----------------------------------------------------------------------------
package les_pkg;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  localparam int SYMBOL_W   = 8;
  localparam int SIZE_W     = 11;
  localparam int POS_W      = 10;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [SIZE_W-1:0]     SIZE_SAT       = '1;
  localparam logic [SYMBOL_W-1:0]   EMPTY_RESET    = 8'd46;
  localparam logic [SYMBOL_W-1:0]   OBSTACLE_RESET = 8'd111;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMPTY_SYMBOL    = 1'b0,
    REG_OBSTACLE_SYMBOL = 1'b1
  } les_reg_t;

endpackage

>>> src/les_if.sv
// ----------------------------------------------------------------------------
// les interfaces
// request channels for map symbols in and square results out
// ----------------------------------------------------------------------------
interface les_in_if
  import les_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                end_of_row;
  logic                end_of_map;

  modport source (output valid, symbol, end_of_row, end_of_map, input ready);
  modport sink   (input valid, symbol, end_of_row, end_of_map, output ready);
endinterface

interface les_out_if
  import les_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] square_size;
  logic [POS_W-1:0]  bottom_row;
  logic [POS_W-1:0]  right_column;

  modport source (output valid, square_size, bottom_row, right_column, input ready);
  modport sink   (input valid, square_size, bottom_row, right_column, output ready);
endinterface

>>> src/largest_empty_square_finder.sv
// result path: the end-of-map symbol passes the stage 1 register, then the result is set in the output register
// throughput: one symbol per cycle while not stalled, set by the line buffer's one read and one write port
// stage 0 reads the line buffer, stage 1 computes the size and writes it back
// the block stalls only while a result waits and another end of map reaches stage 1
// reset (synchronous): counters, pipeline, best square and symbol registers;
// the line buffer keeps its contents and needs no clearing pass
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// maximal-square dynamic programming over a raster stream of map symbols
// ----------------------------------------------------------------------------
module largest_empty_square_finder
  import les_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  les_in_if.sink                in_ch,
  les_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // counters hold the limit itself, addresses only the valid range
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int ACW = $clog2(MAX_COLUMNS);
  localparam int RAW = $clog2(MAX_ROWS);

  typedef struct packed {
    logic           empty;
    logic           first;     // first row or first column
    logic           in_range;
    logic           eor;
    logic           eom;
    logic [ACW-1:0] col;
    logic [RAW-1:0] row;
  } stage_t;

  // symbol registers
  logic [SYMBOL_W-1:0] empty_symbol;
  logic [SYMBOL_W-1:0] obstacle_symbol;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_symbol    <= EMPTY_RESET;
      obstacle_symbol <= OBSTACLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMPTY_SYMBOL:    empty_symbol    <= cfg_data;
        REG_OBSTACLE_SYMBOL: obstacle_symbol <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and stall
  logic   s1_valid;
  stage_t s1;
  logic   out_valid;
  logic   stall;
  logic   accept;
  logic   s1_fire;

  // only a second end of map can wait on a full output register
  assign stall        = s1_valid && s1.eom && out_valid && !out_ch.ready;
  assign in_ch.ready  = !rst && !stall;
  assign accept       = in_ch.valid && in_ch.ready;
  assign s1_fire      = s1_valid && !stall;
  assign out_ch.valid = out_valid;

  // stage 0: position counters, saturating at the limits
  logic [CCW-1:0] col_cnt;
  logic [RCW-1:0] row_cnt;
  logic           in_range;
  logic           is_empty;

  assign in_range = (col_cnt < CCW'(MAX_COLUMNS)) && (row_cnt < RCW'(MAX_ROWS));
  assign is_empty = (in_ch.symbol != obstacle_symbol) && (in_ch.symbol == empty_symbol);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (in_ch.end_of_map) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (in_ch.end_of_row) begin
        col_cnt <= '0;
        if (row_cnt < RCW'(MAX_ROWS)) begin
          row_cnt <= row_cnt + 1'b1;
        end
      end else if (col_cnt < CCW'(MAX_COLUMNS)) begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // line buffer of the previous row's sizes
  logic [SIZE_W-1:0] line_buf [MAX_COLUMNS];
  logic [SIZE_W-1:0] rd_q;
  logic              fwd_q;
  logic [SIZE_W-1:0] fwd_data_q;
  logic [SIZE_W-1:0] size;

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      rd_q <= line_buf[col_cnt[ACW-1:0]];
    end
    if (s1_fire && s1.in_range) begin
      line_buf[s1.col] <= size;
    end
  end

  // a write to the entry being read in the same cycle bypasses the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= s1_fire && s1.in_range && (s1.col == col_cnt[ACW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_q <= size;
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.empty    <= is_empty;
      s1.first    <= (col_cnt == '0) || (row_cnt == '0);
      s1.in_range <= in_range;
      s1.eor      <= in_ch.end_of_row;
      s1.eom      <= in_ch.end_of_map;
      s1.col      <= col_cnt[ACW-1:0];
      s1.row      <= row_cnt[RAW-1:0];
    end
  end

  // stage 1: size of the cell and best square update
  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diag_size;
  logic [SIZE_W-1:0] best_size;
  logic [RAW-1:0]    best_row;
  logic [ACW-1:0]    best_col;

  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] min_dl;
  logic [SIZE_W-1:0] min_all;
  logic [SIZE_W:0]   sum;
  logic [SIZE_W-1:0] left_next;
  logic [SIZE_W-1:0] diag_next;
  logic [SIZE_W-1:0] best_size_next;
  logic [RAW-1:0]    best_row_next;
  logic [ACW-1:0]    best_col_next;

  always_comb begin
    up      = fwd_q ? fwd_data_q : rd_q;
    min_dl  = (diag_size < left_size) ? diag_size : left_size;
    min_all = (min_dl < up) ? min_dl : up;
    sum     = {1'b0, min_all} + 1'b1;

    if (!s1.empty) begin
      size = '0;
    end else if (s1.first) begin
      size = SIZE_W'(1);
    end else if (sum[SIZE_W]) begin
      size = SIZE_SAT;
    end else begin
      size = sum[SIZE_W-1:0];
    end

    // strictly greater keeps the first such cell in raster order
    best_size_next = best_size;
    best_row_next  = best_row;
    best_col_next  = best_col;
    if (s1.in_range && (size > best_size)) begin
      best_size_next = size;
      best_row_next  = s1.row;
      best_col_next  = s1.col;
    end

    left_next = left_size;
    diag_next = diag_size;
    if (s1.in_range) begin
      left_next = size;
      diag_next = up;
    end
    if (s1.eor || s1.eom) begin
      left_next = '0;
      diag_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      best_size <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (s1_fire) begin
      left_size <= left_next;
      diag_size <= diag_next;
      if (s1.eom) begin
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        best_size <= best_size_next;
        best_row  <= best_row_next;
        best_col  <= best_col_next;
      end
    end
  end

  // output register, positions masked to the port width
  logic [RAW+POS_W-1:0] row_ext;
  logic [ACW+POS_W-1:0] col_ext;

  assign row_ext = {{POS_W{1'b0}}, best_row_next};
  assign col_ext = {{POS_W{1'b0}}, best_col_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1.eom) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.eom) begin
      out_ch.square_size  <= best_size_next;
      out_ch.bottom_row   <= row_ext[POS_W-1:0];
      out_ch.right_column <= col_ext[POS_W-1:0];
    end
  end

endmodule

>>> src/les_checker.sv
// ----------------------------------------------------------------------------
// les_checker
// port-level checks on the empty square finder, bound to the top level
// ----------------------------------------------------------------------------
module les_checker
  import les_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_end_of_map,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SIZE_W-1:0] square_size,
  input logic [POS_W-1:0]  bottom_row,
  input logic [POS_W-1:0]  right_column
);

  // a new result traces back to an end of map taken at the input, through the stage 1 and output registers
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_end_of_map, 2))
    else $error("result without a matching end of map");

  // with no empty cell the position stays at the origin
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (square_size == '0)) |-> ((bottom_row == '0) && (right_column == '0)))
    else $error("empty result with a nonzero position");

  // input stalls only behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output free");

  // a waiting result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(square_size) && $stable(bottom_row) && $stable(right_column)))
    else $error("waiting result changed");

endmodule

bind largest_empty_square_finder les_checker u_les_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_end_of_map (in_ch.end_of_map),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .square_size   (out_ch.square_size),
  .bottom_row    (out_ch.bottom_row),
  .right_column  (out_ch.right_column)
);
